// ----- rtl/core/tovc_pkg.sv -----
package tovc_pkg;

   // coordinate width of one vertex field
   localparam int COORD_BITS = 16;

   // fixed-point formats of the cosine path
   localparam int COS_FRAC   = 15;
   localparam int COS_W      = COS_FRAC + 2;
   localparam int NORM_BITS  = 30;
   localparam int ROOT_W     = NORM_BITS + 1;
   localparam int GREEN_W    = 16;
   localparam int CSR_W      = 16;

   localparam logic [CSR_W-1:0]   CRIT_COS_RESET = 16'hA57E;
   localparam logic [GREEN_W-1:0] GREEN_FULL     = 16'hFFFF;

   typedef struct packed {
      logic [COORD_BITS-1:0] ax;
      logic [COORD_BITS-1:0] ay;
      logic [COORD_BITS-1:0] az;
      logic [COORD_BITS-1:0] bx;
      logic [COORD_BITS-1:0] by;
      logic [COORD_BITS-1:0] bz;
      logic [COORD_BITS-1:0] cx;
      logic [COORD_BITS-1:0] cy;
      logic [COORD_BITS-1:0] cz;
   } req_word_type;

   typedef struct packed {
      logic               is_overhang;
      logic [GREEN_W-1:0] green_level;
   } rsp_word_type;

endpackage

// ----- rtl/core/tovc_isqrt_pipe.sv -----
module tovc_isqrt_pipe
   import tovc_pkg::*;
#(
   parameter int ROOT_W = 31,
   parameter int SIDE_W = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [2*ROOT_W-1:0] in_rad,
   input  logic [SIDE_W-1:0]   in_side,
   output logic                out_valid,
   output logic [ROOT_W-1:0]   out_root,
   output logic [SIDE_W-1:0]   out_side
);

   localparam int RAD_W = 2 * ROOT_W;

   logic             vld_ff  [ROOT_W];
   logic [RAD_W-1:0] rad_ff  [ROOT_W];
   logic [RAD_W-1:0] res_ff  [ROOT_W];
   logic [SIDE_W-1:0] side_ff [ROOT_W];

   // one result bit per stage, top bit first
   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      localparam int SH = 2 * (ROOT_W - 1 - k);
      logic              vld_prev;
      logic [RAD_W-1:0]  rad_prev;
      logic [RAD_W-1:0]  res_prev;
      logic [SIDE_W-1:0] side_prev;
      logic [RAD_W:0]    bit_val;
      logic [RAD_W:0]    trial;
      logic              ge;
      logic [RAD_W-1:0]  rad_in;
      logic [RAD_W-1:0]  res_in;

      if (k == 0) begin : g_first
         assign vld_prev  = in_valid;
         assign rad_prev  = in_rad;
         assign res_prev  = '0;
         assign side_prev = in_side;
      end else begin : g_next
         assign vld_prev  = vld_ff[k-1];
         assign rad_prev  = rad_ff[k-1];
         assign res_prev  = res_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      always_comb begin
         bit_val = (RAD_W+1)'(1) << SH;
         trial   = {1'b0, res_prev} + bit_val;
         ge      = {1'b0, rad_prev} >= trial;
         if (ge) begin
            rad_in = RAD_W'({1'b0, rad_prev} - trial);
            res_in = RAD_W'(({1'b0, res_prev} >> 1) + bit_val);
         end else begin
            rad_in = rad_prev;
            res_in = res_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         rad_ff[k]  <= rad_in;
         res_ff[k]  <= res_in;
         side_ff[k] <= side_prev;
      end
   end

   assign out_valid = vld_ff[ROOT_W-1];
   assign out_root  = res_ff[ROOT_W-1][ROOT_W-1:0];
   assign out_side  = side_ff[ROOT_W-1];

endmodule

// ----- rtl/core/tovc_div_pipe.sv -----
module tovc_div_pipe
   import tovc_pkg::*;
#(
   parameter int NUM_W  = 46,
   parameter int DEN_W  = 31,
   parameter int Q_W    = 17,
   parameter int SIDE_W = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [Q_W-1:0]    out_quo,
   output logic [SIDE_W-1:0] out_side
);

   // quotient is known to fit in Q_W bits
   localparam int REM_W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

   logic              vld_ff  [Q_W];
   logic [REM_W-1:0]  rem_ff  [Q_W];
   logic [DEN_W-1:0]  den_ff  [Q_W];
   logic [Q_W-1:0]    quo_ff  [Q_W];
   logic [SIDE_W-1:0] side_ff [Q_W];

   // restoring division, one quotient bit per stage
   for (genvar k = 0; k < Q_W; k++) begin : g_stage
      localparam int SH = Q_W - 1 - k;
      logic              vld_prev;
      logic [REM_W-1:0]  rem_prev;
      logic [DEN_W-1:0]  den_prev;
      logic [Q_W-1:0]    quo_prev;
      logic [SIDE_W-1:0] side_prev;
      logic [REM_W-1:0]  trial;
      logic              ge;
      logic [REM_W-1:0]  rem_in;
      logic [Q_W-1:0]    quo_in;

      if (k == 0) begin : g_first
         assign vld_prev  = in_valid;
         assign rem_prev  = REM_W'(in_num);
         assign den_prev  = in_den;
         assign quo_prev  = '0;
         assign side_prev = in_side;
      end else begin : g_next
         assign vld_prev  = vld_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign den_prev  = den_ff[k-1];
         assign quo_prev  = quo_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      always_comb begin
         trial = REM_W'(den_prev) << SH;
         ge    = rem_prev >= trial;
         if (ge) begin
            rem_in = rem_prev - trial;
            quo_in = quo_prev | (Q_W'(1) << SH);
         end else begin
            rem_in = rem_prev;
            quo_in = quo_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k]  <= rem_in;
         den_ff[k]  <= den_prev;
         quo_ff[k]  <= quo_in;
         side_ff[k] <= side_prev;
      end
   end

   assign out_valid = vld_ff[Q_W-1];
   assign out_quo   = quo_ff[Q_W-1];
   assign out_side  = side_ff[Q_W-1];

endmodule

// ----- rtl/core/triangle_overhang_classifier_unit.sv -----
// channel   ports                          direction  width
// request   start, req_word; busy is out   in         9 x 16 bit vertex coordinates
// response  rsp_strobe, rsp_word           out        overhang flag + 16 bit green
// csr       csr_we, csr_wdata              in         16 bit critical cosine
//
// one word is taken every cycle; the pipeline includes the 31 stage
// square root and the two restoring dividers (17 and 16 stages)
// busy is high only during reset; synchronous reset clears all valid bits
// and loads the default critical cosine
// the receiver cannot stall, so the pipeline never holds
module triangle_overhang_classifier_unit
   import tovc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  req_word_type       req_word,
   output logic               rsp_strobe,
   output rsp_word_type       rsp_word,
   input  logic               csr_we,
   input  logic [CSR_W-1:0]   csr_wdata
);

   localparam int C      = COORD_BITS;
   localparam int DIF_W  = C + 2;
   localparam int PRD_W  = 2 * C + 3;
   localparam int CRS_W  = 2 * C + 4;
   localparam int MAG_W  = 2 * C + 3;
   localparam int SH_W   = $clog2(MAG_W - NORM_BITS + 1);
   localparam int SQ_W   = 2 * NORM_BITS;
   localparam int RAD_W  = 2 * ROOT_W;
   localparam int N1_W   = NORM_BITS + COS_FRAC + 1;
   localparam int Q1_W   = COS_FRAC + 2;
   localparam int SIDE_W = NORM_BITS + 2;

   logic [CSR_W-1:0] crit_ff;

   // critical cosine register
   always_ff @(posedge clock) begin
      if (reset) begin
         crit_ff <= CRIT_COS_RESET;
      end else if (csr_we) begin
         crit_ff <= csr_wdata;
      end
   end

   assign busy = reset;

   // stage 1: edge vectors
   logic                    v1_ff;
   logic signed [DIF_W-1:0] ux_ff, uy_ff, uz_ff, wx_ff, wy_ff, wz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      ux_ff <= $signed(DIF_W'($signed(req_word.bx))) - $signed(DIF_W'($signed(req_word.ax)));
      uy_ff <= $signed(DIF_W'($signed(req_word.by))) - $signed(DIF_W'($signed(req_word.ay)));
      uz_ff <= $signed(DIF_W'($signed(req_word.bz))) - $signed(DIF_W'($signed(req_word.az)));
      wx_ff <= $signed(DIF_W'($signed(req_word.cx))) - $signed(DIF_W'($signed(req_word.ax)));
      wy_ff <= $signed(DIF_W'($signed(req_word.cy))) - $signed(DIF_W'($signed(req_word.ay)));
      wz_ff <= $signed(DIF_W'($signed(req_word.cz))) - $signed(DIF_W'($signed(req_word.az)));
   end

   // stage 2: six partial products of the cross product
   logic                    v2_ff;
   logic signed [PRD_W-1:0] p_ff [6];

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      p_ff[0] <= $signed(PRD_W'(uy_ff)) * $signed(PRD_W'(wz_ff));
      p_ff[1] <= $signed(PRD_W'(uz_ff)) * $signed(PRD_W'(wy_ff));
      p_ff[2] <= $signed(PRD_W'(uz_ff)) * $signed(PRD_W'(wx_ff));
      p_ff[3] <= $signed(PRD_W'(ux_ff)) * $signed(PRD_W'(wz_ff));
      p_ff[4] <= $signed(PRD_W'(ux_ff)) * $signed(PRD_W'(wy_ff));
      p_ff[5] <= $signed(PRD_W'(uy_ff)) * $signed(PRD_W'(wx_ff));
   end

   // stage 3: normal components
   logic                    v3_ff;
   logic signed [CRS_W-1:0] nx_ff, ny_ff, nz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      nx_ff <= CRS_W'(p_ff[0]) - CRS_W'(p_ff[1]);
      ny_ff <= CRS_W'(p_ff[2]) - CRS_W'(p_ff[3]);
      nz_ff <= CRS_W'(p_ff[4]) - CRS_W'(p_ff[5]);
   end

   // stage 4: magnitudes, sign of z, zero normal
   logic             v4_ff, neg4_ff, zero4_ff;
   logic [MAG_W-1:0] mx_ff, my_ff, mz_ff;
   logic [MAG_W-1:0] mx_in, my_in, mz_in;

   always_comb begin
      mx_in = nx_ff[CRS_W-1] ? MAG_W'(-nx_ff) : MAG_W'(nx_ff);
      my_in = ny_ff[CRS_W-1] ? MAG_W'(-ny_ff) : MAG_W'(ny_ff);
      mz_in = nz_ff[CRS_W-1] ? MAG_W'(-nz_ff) : MAG_W'(nz_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      mx_ff    <= mx_in;
      my_ff    <= my_in;
      mz_ff    <= mz_in;
      neg4_ff  <= nz_ff[CRS_W-1];
      zero4_ff <= (nx_ff == '0) && (ny_ff == '0) && (nz_ff == '0);
   end

   // stage 5: common right shift to bring the largest below 2^30
   logic             v5_ff, neg5_ff, zero5_ff;
   logic [MAG_W-1:0] mx5_ff, my5_ff, mz5_ff;
   logic [SH_W-1:0]  sh_ff;
   logic [SH_W-1:0]  sh_in;
   logic [MAG_W-1:0] big_or;

   always_comb begin
      big_or = mx_ff | my_ff | mz_ff;
      sh_in  = '0;
      for (int i = NORM_BITS; i < MAG_W; i++) begin
         if (big_or[i]) begin
            sh_in = SH_W'(i - NORM_BITS + 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else begin
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      mx5_ff   <= mx_ff;
      my5_ff   <= my_ff;
      mz5_ff   <= mz_ff;
      sh_ff    <= sh_in;
      neg5_ff  <= neg4_ff;
      zero5_ff <= zero4_ff;
   end

   // stage 6: apply the shift
   logic                 v6_ff, neg6_ff, zero6_ff;
   logic [NORM_BITS-1:0] sx_ff, sy_ff, sz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else begin
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      sx_ff    <= NORM_BITS'(mx5_ff >> sh_ff);
      sy_ff    <= NORM_BITS'(my5_ff >> sh_ff);
      sz_ff    <= NORM_BITS'(mz5_ff >> sh_ff);
      neg6_ff  <= neg5_ff;
      zero6_ff <= zero5_ff;
   end

   // stage 7: squares
   logic                 v7_ff, neg7_ff, zero7_ff;
   logic [SQ_W-1:0]      qx_ff, qy_ff, qz_ff;
   logic [NORM_BITS-1:0] sz7_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
      end else begin
         v7_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      qx_ff    <= SQ_W'(sx_ff) * SQ_W'(sx_ff);
      qy_ff    <= SQ_W'(sy_ff) * SQ_W'(sy_ff);
      qz_ff    <= SQ_W'(sz_ff) * SQ_W'(sz_ff);
      sz7_ff   <= sz_ff;
      neg7_ff  <= neg6_ff;
      zero7_ff <= zero6_ff;
   end

   // stage 8: squared length
   logic              v8_ff;
   logic [RAD_W-1:0]  len2_ff;
   logic [SIDE_W-1:0] side8_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v8_ff <= 1'b0;
      end else begin
         v8_ff <= v7_ff;
      end
   end

   always_ff @(posedge clock) begin
      len2_ff  <= RAD_W'(qx_ff) + RAD_W'(qy_ff) + RAD_W'(qz_ff);
      side8_ff <= {neg7_ff, zero7_ff, sz7_ff};
   end

   // length of the normal
   logic              sq_valid;
   logic [ROOT_W-1:0] sq_root;
   logic [SIDE_W-1:0] sq_side;

   tovc_isqrt_pipe #(
      .ROOT_W (ROOT_W),
      .SIDE_W (SIDE_W)
   ) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v8_ff),
      .in_rad    (len2_ff),
      .in_side   (side8_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // rounded |z| / length in Q1.15
   logic [N1_W-1:0] d1_num;
   logic            d1_valid;
   logic [Q1_W-1:0] d1_quo;
   logic [1:0]      d1_side;

   assign d1_num = (N1_W'(sq_side[NORM_BITS-1:0]) << COS_FRAC) + N1_W'(sq_root >> 1);

   tovc_div_pipe #(
      .NUM_W  (N1_W),
      .DEN_W  (ROOT_W),
      .Q_W    (Q1_W),
      .SIDE_W (2)
   ) u_cos_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .in_num    (d1_num),
      .in_den    (sq_root),
      .in_side   (sq_side[SIDE_W-1 -: 2]),
      .out_valid (d1_valid),
      .out_quo   (d1_quo),
      .out_side  (d1_side)
   );

   // signed cosine, threshold compare, green operands
   logic                    vc_ff, ovh_ff;
   logic [GREEN_W-1:0]      gnum_ff, gden_ff;
   logic signed [COS_W-1:0] cos_in;
   logic signed [COS_W-1:0] crit_ext;
   logic                    ovh_in;
   logic [COS_W-1:0]        bias_in;

   always_comb begin
      if (d1_side[0]) begin
         cos_in = '0;
      end else if (d1_side[1]) begin
         cos_in = -$signed(COS_W'(d1_quo));
      end else begin
         cos_in = $signed(COS_W'(d1_quo));
      end
      crit_ext = $signed(COS_W'($signed(crit_ff)));
      ovh_in   = cos_in < crit_ext;
      bias_in  = COS_W'(cos_in) + (COS_W'(1) << COS_FRAC);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= 1'b0;
      end else begin
         vc_ff <= d1_valid;
      end
   end

   always_ff @(posedge clock) begin
      ovh_ff  <= ovh_in;
      gnum_ff <= bias_in[GREEN_W-1:0];
      gden_ff <= {~crit_ff[CSR_W-1], crit_ff[CSR_W-2:0]};
   end

   // green = (cos + 1) / (crit + 1) in Q0.16
   logic               d2_valid;
   logic [GREEN_W-1:0] d2_quo;
   logic               d2_ovh;

   tovc_div_pipe #(
      .NUM_W  (2 * GREEN_W),
      .DEN_W  (GREEN_W),
      .Q_W    (GREEN_W),
      .SIDE_W (1)
   ) u_green_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vc_ff),
      .in_num    ({gnum_ff, {GREEN_W{1'b0}}}),
      .in_den    (gden_ff),
      .in_side   (ovh_ff),
      .out_valid (d2_valid),
      .out_quo   (d2_quo),
      .out_side  (d2_ovh)
   );

   // output word register
   logic         rsp_strobe_ff;
   rsp_word_type rsp_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= d2_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff.is_overhang <= d2_ovh;
      rsp_word_ff.green_level <= d2_ovh ? d2_quo : GREEN_FULL;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

endmodule
